>>> design/per_domain_round_robin_table_defines.svh
// assertion macros for the per-domain round-robin table checker
// needs clk and arst_n in the scope where a macro is used
`ifndef PER_DOMAIN_ROUND_ROBIN_TABLE_DEFINES_SVH
`define PER_DOMAIN_ROUND_ROBIN_TABLE_DEFINES_SVH

// same-cycle implication, masked during reset
`define PDRRT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pdrrt checker: same-cycle property failed");

// next-cycle implication, masked during reset
`define PDRRT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pdrrt checker: next-cycle property failed");

`endif

>>> design/pdrrt_pkg.sv
// shared types and constants for the per-domain round-robin table
// no dependencies
`timescale 1ns / 1ps

package pdrrt_pkg;

	// default sizing
	localparam int DOMAINS_DEF = 8;
	localparam int SERVERS_DEF = 16;

	// fixed field widths
	localparam int REQ_W  = 2;
	localparam int DOM_W  = 3;
	localparam int RANK_W = 16;
	localparam int STAT_W = 2;

	// request kinds
	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT  = 2'd0,
		REQ_CURRENT = 2'd1,
		REQ_NEXT    = 2'd2,
		REQ_UNUSED  = 2'd3
	} req_kind_t;

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 2'd0,
		ST_PRESENT = 2'd1,
		ST_FULL    = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_DOM,
		S_SCAN,
		S_FETCH,
		S_DONE
	} state_t;

	// request beat
	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [DOM_W-1:0]  domain_id;
		logic [RANK_W-1:0] rank;
	} req_t;

	// response beat
	typedef struct packed {
		logic [RANK_W-1:0] rank_out;
		logic [STAT_W-1:0] status;
	} rsp_t;

	// memory port strobes
	typedef struct packed {
		logic rd;
		logic wr;
	} mem_cmd_t;

endpackage

>>> design/per_domain_round_robin_table.sv
// Per-domain round-robin server table. Each request beat (insert, current or
// next) yields exactly one response beat. Requests are handled one at a time:
// an insert on a non-empty list reads the domain's stored ranks one per cycle
// through the single port of the rank memory to check for a duplicate, and
// stops early when one turns up; an empty list is appended to without a scan.
// Current and next read the domain's pointer and then one stored rank; an
// unused request type or an out-of-range domain is answered without a memory
// access. A response waiting in the output register does not hold up
// acceptance of the next request, but that request's response waits until the
// output register is free. No clearing pass after reset: per-domain valid bits
// make every domain start empty.
// depends on pdrrt_pkg, pdrrt_dom_table, pdrrt_rank_store, pdrrt_ctrl
`timescale 1ns / 1ps

module per_domain_round_robin_table #(
	parameter int DOMAINS = pdrrt_pkg::DOMAINS_DEF,
	parameter int SERVERS_PER_DOMAIN = pdrrt_pkg::SERVERS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  pdrrt_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output pdrrt_pkg::rsp_t rsp
);
	import pdrrt_pkg::*;

	localparam int CW  = $clog2(SERVERS_PER_DOMAIN + 1);
	localparam int PW  = (SERVERS_PER_DOMAIN > 1) ? $clog2(SERVERS_PER_DOMAIN) : 1;
	localparam int DIW = (DOMAINS > 1) ? $clog2(DOMAINS) : 1;
	localparam int DEPTH = DOMAINS * SERVERS_PER_DOMAIN;
	localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	mem_cmd_t          dt_cmd, rs_cmd;
	logic [DIW-1:0]    dt_addr;
	logic [CW-1:0]     dt_wr_cnt, dt_rd_cnt;
	logic [PW-1:0]     dt_wr_ptr, dt_rd_ptr;
	logic [AW-1:0]     rs_addr;
	logic [RANK_W-1:0] rs_wr_data, rs_rd_data;

	// sequencer
	pdrrt_ctrl #(
		.DOMAINS (DOMAINS),
		.SERVERS (SERVERS_PER_DOMAIN)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.dt_cmd     (dt_cmd),
		.dt_addr    (dt_addr),
		.dt_wr_cnt  (dt_wr_cnt),
		.dt_wr_ptr  (dt_wr_ptr),
		.dt_rd_cnt  (dt_rd_cnt),
		.dt_rd_ptr  (dt_rd_ptr),
		.rs_cmd     (rs_cmd),
		.rs_addr    (rs_addr),
		.rs_wr_data (rs_wr_data),
		.rs_rd_data (rs_rd_data)
	);

	// count and pointer per domain
	pdrrt_dom_table #(
		.DOMAINS (DOMAINS),
		.SERVERS (SERVERS_PER_DOMAIN)
	) u_dom_table (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (dt_cmd),
		.addr   (dt_addr),
		.wr_cnt (dt_wr_cnt),
		.wr_ptr (dt_wr_ptr),
		.rd_cnt (dt_rd_cnt),
		.rd_ptr (dt_rd_ptr)
	);

	// stored ranks
	pdrrt_rank_store #(
		.DOMAINS (DOMAINS),
		.SERVERS (SERVERS_PER_DOMAIN)
	) u_rank_store (
		.clk     (clk),
		.cmd     (rs_cmd),
		.addr    (rs_addr),
		.wr_data (rs_wr_data),
		.rd_data (rs_rd_data)
	);

endmodule

>>> design/pdrrt_dom_table.sv
// per-domain entry count and round-robin pointer, one memory word per domain
// depends on pdrrt_pkg; valid bits make unwritten domains read as zero
`timescale 1ns / 1ps

module pdrrt_dom_table #(
	parameter int DOMAINS = pdrrt_pkg::DOMAINS_DEF,
	parameter int SERVERS = pdrrt_pkg::SERVERS_DEF,
	localparam int CW  = $clog2(SERVERS + 1),
	localparam int PW  = (SERVERS > 1) ? $clog2(SERVERS) : 1,
	localparam int DIW = (DOMAINS > 1) ? $clog2(DOMAINS) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pdrrt_pkg::mem_cmd_t cmd,
	input  logic [DIW-1:0]     addr,
	input  logic [CW-1:0]      wr_cnt,
	input  logic [PW-1:0]      wr_ptr,
	output logic [CW-1:0]      rd_cnt,
	output logic [PW-1:0]      rd_ptr
);
	import pdrrt_pkg::*;

	logic [CW+PW-1:0] mem [DOMAINS];
	logic [DOMAINS-1:0] valid_q;
	logic [CW+PW-1:0] rd_q;
	logic rd_vld_q;

	// memory array, registered read
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[addr] <= {wr_cnt, wr_ptr};
		end
		if (cmd.rd) begin
			rd_q <= mem[addr];
		end
	end

	// per-domain valid bits and read qualifier
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (cmd.wr) begin
				valid_q[addr] <= 1'b1;
			end
			if (cmd.rd) begin
				rd_vld_q <= valid_q[addr];
			end
		end
	end

	// never-written domain reads as empty
	assign rd_cnt = rd_vld_q ? rd_q[CW+PW-1:PW] : '0;
	assign rd_ptr = rd_vld_q ? rd_q[PW-1:0] : '0;

endmodule

>>> design/pdrrt_rank_store.sv
// rank memory, one row of slots per domain, single port, registered read
// depends on pdrrt_pkg
`timescale 1ns / 1ps

module pdrrt_rank_store #(
	parameter int DOMAINS = pdrrt_pkg::DOMAINS_DEF,
	parameter int SERVERS = pdrrt_pkg::SERVERS_DEF,
	localparam int DEPTH = DOMAINS * SERVERS,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                          clk,
	input  pdrrt_pkg::mem_cmd_t           cmd,
	input  logic [AW-1:0]                 addr,
	input  logic [pdrrt_pkg::RANK_W-1:0]  wr_data,
	output logic [pdrrt_pkg::RANK_W-1:0]  rd_data
);
	import pdrrt_pkg::*;

	logic [RANK_W-1:0] mem [DEPTH];
	logic [RANK_W-1:0] rd_q;

	// storage, contents undefined until written
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[addr] <= wr_data;
		end
		if (cmd.rd) begin
			rd_q <= mem[addr];
		end
	end

	assign rd_data = rd_q;

endmodule

>>> design/pdrrt_ctrl.sv
// request sequencer: domain lookup, duplicate scan, pointer update, response register
// depends on pdrrt_pkg; drives pdrrt_dom_table and pdrrt_rank_store
`timescale 1ns / 1ps

module pdrrt_ctrl #(
	parameter int DOMAINS = pdrrt_pkg::DOMAINS_DEF,
	parameter int SERVERS = pdrrt_pkg::SERVERS_DEF,
	localparam int CW  = $clog2(SERVERS + 1),
	localparam int PW  = (SERVERS > 1) ? $clog2(SERVERS) : 1,
	localparam int DIW = (DOMAINS > 1) ? $clog2(DOMAINS) : 1,
	localparam int DEPTH = DOMAINS * SERVERS,
	localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  pdrrt_pkg::req_t              req,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output pdrrt_pkg::rsp_t              rsp,
	output pdrrt_pkg::mem_cmd_t          dt_cmd,
	output logic [DIW-1:0]               dt_addr,
	output logic [CW-1:0]                dt_wr_cnt,
	output logic [PW-1:0]                dt_wr_ptr,
	input  logic [CW-1:0]                dt_rd_cnt,
	input  logic [PW-1:0]                dt_rd_ptr,
	output pdrrt_pkg::mem_cmd_t          rs_cmd,
	output logic [AW-1:0]                rs_addr,
	output logic [pdrrt_pkg::RANK_W-1:0] rs_wr_data,
	input  logic [pdrrt_pkg::RANK_W-1:0] rs_rd_data
);
	import pdrrt_pkg::*;

	localparam logic [CW-1:0] CNT_FULL = CW'(SERVERS);

	state_t            state_q, state_d;
	req_kind_t         kind_q;
	logic [RANK_W-1:0] rank_q;
	logic [DIW-1:0]    dom_q;
	logic [AW-1:0]     base_q;
	logic [CW-1:0]     cnt_q;
	logic [PW-1:0]     ptr_q;
	logic [CW-1:0]     idx_q;
	rsp_t              res_q, res_d;
	logic              res_load;
	logic              rsp_valid_q;
	rsp_t              rsp_q;
	logic              accept;
	logic              dom_ok;
	logic [DIW-1:0]    req_dom;
	logic [CW-1:0]     slot;
	logic [PW-1:0]     p_cur;
	logic [CW-1:0]     p_inc;
	logic [PW-1:0]     p_sel;
	logic              idx_step;
	logic              rsp_load;

	assign req_dom = DIW'(req.domain_id);
	assign dom_ok  = (32'(req.domain_id) < DOMAINS);
	assign accept  = req_valid && req_ready;

	// pointer clamp and advance for current/next
	always_comb begin
		p_cur = (CW'(dt_rd_ptr) >= dt_rd_cnt) ? '0 : dt_rd_ptr;
		p_inc = CW'(p_cur) + CW'(1);
		if (kind_q == REQ_NEXT) begin
			p_sel = (p_inc >= dt_rd_cnt) ? '0 : PW'(p_inc);
		end else begin
			p_sel = p_cur;
		end
	end

	// next state, memory strobes and result
	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		dt_cmd     = '0;
		dt_addr    = dom_q;
		dt_wr_cnt  = cnt_q + CW'(1);
		dt_wr_ptr  = ptr_q;
		rs_cmd     = '0;
		slot       = idx_q;
		rs_wr_data = rank_q;
		res_d      = res_q;
		res_load   = 1'b0;
		idx_step   = 1'b0;
		rsp_load   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				dt_addr   = req_dom;
				if (req_valid) begin
					if (req.req_type == REQ_UNUSED) begin
						res_d    = '{rank_out: '0, status: ST_OK};
						res_load = 1'b1;
						state_d  = S_DONE;
					end else if (!dom_ok) begin
						res_d.rank_out = '0;
						res_d.status   = (req.req_type == REQ_INSERT) ? ST_FULL : ST_EMPTY;
						res_load       = 1'b1;
						state_d        = S_DONE;
					end else begin
						dt_cmd.rd = 1'b1;
						state_d   = S_DOM;
					end
				end
			end
			S_DOM: begin
				if (kind_q == REQ_INSERT) begin
					slot = '0;
					if (dt_rd_cnt == '0) begin
						// empty list: append straight away
						rs_cmd.wr = 1'b1;
						dt_cmd.wr = 1'b1;
						dt_wr_cnt = CW'(1);
						dt_wr_ptr = dt_rd_ptr;
						res_d     = '{rank_out: rank_q, status: ST_OK};
						res_load  = 1'b1;
						state_d   = S_DONE;
					end else begin
						rs_cmd.rd = 1'b1;
						state_d   = S_SCAN;
					end
				end else if (dt_rd_cnt == '0) begin
					res_d    = '{rank_out: '0, status: ST_EMPTY};
					res_load = 1'b1;
					state_d  = S_DONE;
				end else begin
					slot      = CW'(p_sel);
					rs_cmd.rd = 1'b1;
					dt_cmd.wr = (kind_q == REQ_NEXT);
					dt_wr_cnt = dt_rd_cnt;
					dt_wr_ptr = p_sel;
					state_d   = S_FETCH;
				end
			end
			S_SCAN: begin
				// compare slot idx_q-1 while fetching slot idx_q
				if (rs_rd_data == rank_q) begin
					res_d    = '{rank_out: rank_q, status: ST_PRESENT};
					res_load = 1'b1;
					state_d  = S_DONE;
				end else if (idx_q == cnt_q) begin
					if (cnt_q == CNT_FULL) begin
						res_d = '{rank_out: '0, status: ST_FULL};
					end else begin
						slot      = cnt_q;
						rs_cmd.wr = 1'b1;
						dt_cmd.wr = 1'b1;
						res_d     = '{rank_out: rank_q, status: ST_OK};
					end
					res_load = 1'b1;
					state_d  = S_DONE;
				end else begin
					rs_cmd.rd = 1'b1;
					idx_step  = 1'b1;
				end
			end
			S_FETCH: begin
				res_d    = '{rank_out: rs_rd_data, status: ST_OK};
				res_load = 1'b1;
				state_d  = S_DONE;
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		rs_addr = base_q + AW'(slot);
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// request fields and working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= req_kind_t'(req.req_type);
			rank_q <= req.rank;
			dom_q  <= req_dom;
			base_q <= AW'(32'(req_dom) * SERVERS);
		end
		if (state_q == S_DOM) begin
			cnt_q <= dt_rd_cnt;
			ptr_q <= dt_rd_ptr;
			idx_q <= CW'(1);
		end else if (idx_step) begin
			idx_q <= idx_q + CW'(1);
		end
		if (res_load) begin
			res_q <= res_d;
		end
		if (rsp_load) begin
			rsp_q <= res_q;
		end
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> design/pdrrt_checker.sv
// port-level checks for the per-domain round-robin table, bound to the top level
// depends on pdrrt_pkg and per_domain_round_robin_table_defines.svh
`timescale 1ns / 1ps
`include "per_domain_round_robin_table_defines.svh"

module pdrrt_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_ready,
	input pdrrt_pkg::req_t req,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input pdrrt_pkg::rsp_t rsp
);
	import pdrrt_pkg::*;

	logic req_acc;
	logic rsp_acc;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	// a stalled response beat holds
	`PDRRT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

	// one request in flight: no acceptance straight after another
	`PDRRT_ASSERT_NEXT(a_one_in_flight, req_acc, !req_ready)

	// full and empty results carry no rank
	`PDRRT_ASSERT_NOW(a_err_rank_zero, rsp_valid && (rsp.status == ST_FULL || rsp.status == ST_EMPTY), rsp.rank_out == '0)

	// with no beat waiting, no response beat is taken straight after a request is accepted
	`PDRRT_ASSERT_NEXT(a_no_early_rsp, req_acc && !rsp_valid, !rsp_acc)

endmodule

bind per_domain_round_robin_table pdrrt_checker u_pdrrt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

>>> test/tb.sv
// self-checking bench for the per-domain round-robin server table
// depends on pdrrt_pkg and per_domain_round_robin_table
`timescale 1ns / 1ps

module tb;
	import pdrrt_pkg::*;

	localparam int DOMAINS      = DOMAINS_DEF;
	localparam int SERVERS      = SERVERS_DEF;
	localparam int RANDOM_BEATS = 700;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int SETTLE_CYCLES = 40;

	// request beat plus a flag that holds it back until all responses are in
	typedef struct {
		req_t beat;
		bit   hold;
	} queued_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	queued_req_t req_queue[$];
	rsp_t        rsp_expected[$];

	// mirror of the table contents
	logic [RANK_W-1:0] mirror_ranks [DOMAINS][SERVERS];
	int                mirror_count [DOMAINS];
	int                mirror_ptr   [DOMAINS];

	bit req_taken = 1'b0;
	bit rsp_taken = 1'b0;
	bit req_burst = 1'b0;
	bit rsp_burst = 1'b0;
	int req_gap = 0;
	int rsp_stall = 0;
	int cycle_count = 0;
	int fail_count = 0;

	per_domain_round_robin_table uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// idle length for one beat, none while in a burst
	function automatic int idle_draw(bit burst);
		return burst ? 0 : $urandom_range(0, 19);
	endfunction

	// works out the response to one request and updates the mirror
	function automatic rsp_t table_lookup(req_t beat);
		rsp_t      res;
		req_kind_t kind;
		int        d;
		int        cnt;
		int        p;
		kind = req_kind_t'(beat.req_type);
		d = beat.domain_id;
		res.rank_out = '0;
		res.status = ST_OK;
		if (kind == REQ_UNUSED)
			return res;
		if (d >= DOMAINS) begin
			res.status = (kind == REQ_INSERT) ? ST_FULL : ST_EMPTY;
			return res;
		end
		cnt = mirror_count[d];
		if (kind == REQ_INSERT) begin
			for (int i = 0; i < cnt; i++) begin
				if (mirror_ranks[d][i] == beat.rank) begin
					res.rank_out = beat.rank;
					res.status = ST_PRESENT;
					return res;
				end
			end
			if (cnt >= SERVERS) begin
				res.status = ST_FULL;
				return res;
			end
			mirror_ranks[d][cnt] = beat.rank;
			mirror_count[d] = cnt + 1;
			res.rank_out = beat.rank;
			return res;
		end
		if (cnt == 0) begin
			res.status = ST_EMPTY;
			return res;
		end
		p = mirror_ptr[d];
		if (p >= cnt)
			p = 0;
		if (kind == REQ_NEXT) begin
			p = p + 1;
			if (p >= cnt)
				p = 0;
			mirror_ptr[d] = p;
		end
		res.rank_out = mirror_ranks[d][p];
		return res;
	endfunction

	task automatic queue_req(req_kind_t kind, int dom, int rank, bit hold);
		queued_req_t q;
		q.beat.req_type = kind;
		q.beat.domain_id = dom[DOM_W-1:0];
		q.beat.rank = rank[RANK_W-1:0];
		q.hold = hold;
		req_queue.push_back(q);
	endtask

	// request driver, changes at the falling edge
	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_taken)) begin
			if (req_gap > 0) begin
				req_gap = req_gap - 1;
				req_valid <= 1'b0;
			end else if (req_queue.size() > 0 &&
					!(req_queue[0].hold && rsp_expected.size() > 0)) begin
				req <= req_queue[0].beat;
				req_valid <= 1'b1;
				void'(req_queue.pop_front());
				if ($urandom_range(0, 29) == 0)
					req_burst = !req_burst;
				req_gap = idle_draw(req_burst);
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// response back-pressure, a fresh stall after every beat taken
	always @(negedge clk) begin
		if (rsp_taken) begin
			if ($urandom_range(0, 29) == 0)
				rsp_burst = !rsp_burst;
			rsp_stall = idle_draw(rsp_burst);
		end
		if (rsp_stall > 0) begin
			rsp_stall = rsp_stall - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	// monitor: compare responses first, then record newly accepted requests
	always @(posedge clk) begin
		rsp_t want;
		req_taken <= arst_n && req_valid && req_ready;
		rsp_taken <= arst_n && rsp_valid && rsp_ready;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (rsp_expected.size() == 0) begin
					$error("response beat with none expected: rank_out %0d status %0d",
						rsp.rank_out, rsp.status);
					fail_count++;
				end else begin
					want = rsp_expected.pop_front();
					if (rsp.rank_out !== want.rank_out) begin
						$error("rank_out: expected %0d, got %0d", want.rank_out, rsp.rank_out);
						fail_count++;
					end
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						fail_count++;
					end
				end
			end
			if (req_valid && req_ready)
				rsp_expected.push_back(table_lookup(req));
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		req_kind_t kind;
		int        sel;
		int        dom;
		int        rank;
		for (int d = 0; d < DOMAINS; d++) begin
			mirror_count[d] = 0;
			mirror_ptr[d] = 0;
		end

		// empty domain, unused request type, extremes of rank
		queue_req(REQ_CURRENT, 0, 0, 1'b0);
		queue_req(REQ_NEXT, 0, 16'hFFFF, 1'b0);
		queue_req(REQ_UNUSED, 0, 16'hFFFF, 1'b0);
		queue_req(REQ_INSERT, 0, 0, 1'b0);
		queue_req(REQ_INSERT, 0, 16'hFFFF, 1'b0);
		queue_req(REQ_INSERT, 0, 0, 1'b0);
		queue_req(REQ_CURRENT, 0, 0, 1'b0);
		queue_req(REQ_NEXT, 0, 0, 1'b0);
		// pointer wraps back to the first entry
		queue_req(REQ_NEXT, 0, 0, 1'b0);

		// fill the last domain, then a new rank and a repeated one on the full list
		for (int i = 0; i < SERVERS; i++)
			queue_req(REQ_INSERT, 7, i * 16'h1111, 1'b0);
		queue_req(REQ_INSERT, 7, 16'h1234, 1'b0);
		queue_req(REQ_INSERT, 7, 16'hFFFF, 1'b0);
		queue_req(REQ_CURRENT, 7, 0, 1'b0);

		// random mix, small rank pools so repeats and full lists are common
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			sel = $urandom_range(0, 99);
			dom = $urandom_range(0, 7);
			if (sel < 45)
				kind = REQ_INSERT;
			else if (sel < 70)
				kind = REQ_NEXT;
			else if (sel < 93)
				kind = REQ_CURRENT;
			else
				kind = REQ_UNUSED;
			case ($urandom_range(0, 3))
				0: rank = $urandom_range(0, 65535);
				1: rank = 16'hFFFF - $urandom_range(0, 23);
				default: rank = $urandom_range(0, 23);
			endcase
			queue_req(kind, dom, rank, (n % 150) == 0);
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for the last beat to go out and its response to come back
		while (req_queue.size() > 0 || req_valid)
			@(posedge clk);
		while (rsp_expected.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> sim.f
+incdir+design
design/pdrrt_pkg.sv
design/pdrrt_dom_table.sv
design/pdrrt_rank_store.sv
design/pdrrt_ctrl.sv
design/per_domain_round_robin_table.sv
design/pdrrt_checker.sv
test/tb.sv
